// File: hw/rtl/psp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psp_pkg: shared types and constants of the point screen projector
// Widths of the Q16.16 datapath, register indexes, item kinds, saturation.
// ----------------------------------------------------------------------------
package psp_pkg;

    localparam int DATA_W    = 32;  // Q16.16 word
    localparam int FRAC_W    = 16;  // fraction bits
    localparam int WIDE_W    = 50;  // clip sums and scaled products
    localparam int MAT_DEPTH = 16;
    localparam int MAT_AW    = 4;
    localparam int CFG_AW    = 4;   // byte address of four 32-bit registers
    localparam int QUO_BITS  = 31;  // quotient bits below the saturation point

    localparam logic signed [DATA_W:0]   HALF_Q16        = 33'sd32768;
    localparam logic [15:0]              THRESHOLD_RESET = 16'd655;
    localparam logic signed [DATA_W-1:0] Q16_MAX         = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] Q16_MIN         = 32'sh8000_0000;

    typedef enum logic {
        KIND_LOAD  = 1'b0,
        KIND_FRAME = 1'b1
    } kind_t;

    typedef enum logic [1:0] {
        REG_WIDTH     = 2'd0,
        REG_HEIGHT    = 2'd1,
        REG_ORTHO     = 2'd2,
        REG_THRESHOLD = 2'd3
    } cfg_reg_t;

    typedef logic signed [DATA_W-1:0] q16_t;
    typedef logic signed [WIDE_W-1:0] wide_t;

    // matrix write port
    typedef struct packed {
        logic              we;
        logic [MAT_AW-1:0] addr;
        q16_t              data;
    } mat_wr_t;

    // clip coordinates of one point
    typedef struct packed {
        wide_t cx;
        wide_t cy;
        wide_t cz;
        wide_t w;
    } clip_t;

    function automatic q16_t sat32(input wide_t v);
        q16_t r;
        if (!v[WIDE_W-1] && (v[WIDE_W-2:DATA_W-1] != '0))
            r = Q16_MAX;
        else if (v[WIDE_W-1] && (v[WIDE_W-2:DATA_W-1] != '1))
            r = Q16_MIN;
        else
            r = v[DATA_W-1:0];
        return r;
    endfunction

endpackage
`default_nettype wire

// File: hw/rtl/psp_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psp_in_if: input item channel
// Valid/ready handshake with load and frame payload fields.
// ----------------------------------------------------------------------------
interface psp_in_if;
    logic               valid;
    logic               ready;
    logic               kind;
    logic [3:0]         entry_index;
    logic signed [31:0] entry_value;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;

    modport source (
        output valid, kind, entry_index, entry_value, point_x, point_y, point_z,
        input  ready
    );
    modport sink (
        input  valid, kind, entry_index, entry_value, point_x, point_y, point_z,
        output ready
    );
endinterface
`default_nettype wire

// File: hw/rtl/psp_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psp_out_if: result item channel
// Valid/ready handshake carrying visibility and the stored screen position.
// ----------------------------------------------------------------------------
interface psp_out_if;
    logic               valid;
    logic               ready;
    logic               visible;
    logic               moved;
    logic signed [31:0] screen_x;
    logic signed [31:0] screen_y;
    logic signed [31:0] depth;
    logic               depth_valid;

    modport source (
        output valid, visible, moved, screen_x, screen_y, depth, depth_valid,
        input  ready
    );
    modport sink (
        input  valid, visible, moved, screen_x, screen_y, depth, depth_valid,
        output ready
    );
endinterface
`default_nettype wire

// File: hw/rtl/point_screen_projector.sv
`default_nettype none
// ----------------------------------------------------------------------------
// point_screen_projector: view-projection, clip test and viewport mapping
// Projects a tracked world point to a Q16.16 screen position per frame item.
// ----------------------------------------------------------------------------
// A load item (kind 0) writes one Q16.16 entry of the row-major 4x4
// view-projection matrix and is done in its accept cycle; it gives no result.
// A frame item (kind 1) projects (x, y, z, 1) and always gives one result.
// With a zero viewport width or height the item goes from accept straight to
// the final step. Otherwise the 16 matrix entries are read one per cycle from
// a synchronous RAM and pass through one 32x32 multiplier and an accumulator,
// then, after the clip test, x/(2w) and -y/(2w) run side by side in two
// radix-2 dividers for 31 quotient bits, followed by scale, saturate and
// compare steps; the result then moves into the output register once that
// is free. No new item is taken before that: the input is ready again as
// soon as the result moves into the output register, so the next item is
// taken while a result still waits downstream.
// A point with w <= 0 is invisible and leaves the stored position unchanged.
// The stored position, depth and depth-valid flag are replaced only when the
// new values differ by at least change_threshold (or depth validity changes);
// every result carries the stored values after the item. Matrix entries have
// no reset: project only after all 16 have been loaded. Registers at byte
// offsets 0x0 width, 0x4 height, 0x8 orthographic, 0xC change_threshold;
// write them only while the block is idle.
// ----------------------------------------------------------------------------
module point_screen_projector (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    psp_in_if.sink           in_ch,
    psp_out_if.source        out_ch
);
    import psp_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_MAC   = 7'b0000010,
        ST_CHECK = 7'b0000100,
        ST_DIV   = 7'b0001000,
        ST_SCALE = 7'b0010000,
        ST_SAT   = 7'b0100000,
        ST_FIN   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [15:0] vp_width_reg;
    logic [15:0] vp_height_reg;
    logic        ortho_reg;
    logic [15:0] thr_reg;
    logic        cfg_wr;
    cfg_reg_t    cfg_sel;

    // item payload and work registers
    q16_t  px_reg, py_reg, pz_reg;
    logic  ok_reg;       // viewport ready and w > 0
    logic  vis_reg;
    wide_t prod_x_reg, prod_y_reg;
    q16_t  nx_reg, ny_reg, nd_reg;
    logic  nv_reg;

    // stored position
    q16_t last_x_reg, last_y_reg, last_d_reg;
    logic last_dv_reg;

    // output register
    logic out_valid_reg;
    logic out_vis_reg, out_moved_reg, out_dv_reg;
    q16_t out_x_reg, out_y_reg, out_d_reg;

    // datapath links
    mat_wr_t mat_wr;
    logic    mac_start, mac_done;
    clip_t   clip;
    logic    div_start, div_x_done, div_y_done;
    q16_t    ratio_x, ratio_y;
    wide_t   neg_cy;

    logic        in_fire, vp_ok, fin_fire, w_pos, in_box, same, moved;
    wide_t       abs_cx, abs_cy, abs_cz;
    logic signed [DATA_W:0] sx_sum, sy_sum, dx, dy, dd, adx, ady, add_d;

    // ------------------------------------------------------------------
    // APB register file
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_sel = cfg_reg_t'(paddr[CFG_AW-1:2]);

    always_comb
    begin
        case (cfg_sel)
            REG_WIDTH:     prdata = 32'(vp_width_reg);
            REG_HEIGHT:    prdata = 32'(vp_height_reg);
            REG_ORTHO:     prdata = 32'(ortho_reg);
            REG_THRESHOLD: prdata = 32'(thr_reg);
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vp_width_reg  <= '0;
            vp_height_reg <= '0;
            ortho_reg     <= 1'b0;
            thr_reg       <= THRESHOLD_RESET;
        end
        else if (cfg_wr)
        begin
            case (cfg_sel)
                REG_WIDTH:     vp_width_reg  <= pwdata[15:0];
                REG_HEIGHT:    vp_height_reg <= pwdata[15:0];
                REG_ORTHO:     ortho_reg     <= pwdata[0];
                REG_THRESHOLD: thr_reg       <= pwdata[15:0];
                default:       ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input side: loads go straight to the matrix RAM
    // ------------------------------------------------------------------
    assign in_ch.ready = (state_reg == ST_IDLE);
    assign in_fire     = in_ch.valid && in_ch.ready;
    assign vp_ok       = (vp_width_reg != '0) && (vp_height_reg != '0);

    assign mat_wr.we   = in_fire && (in_ch.kind == KIND_LOAD);
    assign mat_wr.addr = in_ch.entry_index;
    assign mat_wr.data = in_ch.entry_value;
    assign mac_start   = in_fire && (in_ch.kind == KIND_FRAME) && vp_ok;

    psp_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (mat_wr),
        .start (mac_start),
        .px    (px_reg),
        .py    (py_reg),
        .pz    (pz_reg),
        .done  (mac_done),
        .clip  (clip)
    );

    // ------------------------------------------------------------------
    // Clip test: w > 0 and |cx|,|cy|,|cz| <= w
    // ------------------------------------------------------------------
    always_comb
    begin
        w_pos  = !clip.w[WIDE_W-1] && (clip.w != '0);
        abs_cx = clip.cx[WIDE_W-1] ? -clip.cx : clip.cx;
        abs_cy = clip.cy[WIDE_W-1] ? -clip.cy : clip.cy;
        abs_cz = clip.cz[WIDE_W-1] ? -clip.cz : clip.cz;
        in_box = ($unsigned(abs_cx) <= $unsigned(clip.w)) &&
                 ($unsigned(abs_cy) <= $unsigned(clip.w)) &&
                 ($unsigned(abs_cz) <= $unsigned(clip.w));
    end

    assign div_start = (state_reg == ST_CHECK) && w_pos;
    assign neg_cy    = -clip.cy;  // screen y runs downward

    psp_div u_div_x (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (clip.cx),
        .den   (clip.w),
        .done  (div_x_done),
        .quo   (ratio_x)
    );

    psp_div u_div_y (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (neg_cy),
        .den   (clip.w),
        .done  (div_y_done),
        .quo   (ratio_y)
    );

    // ------------------------------------------------------------------
    // Viewport mapping and move detection
    // ------------------------------------------------------------------
    always_comb
    begin
        sx_sum = (DATA_W+1)'(ratio_x) + HALF_Q16;
        sy_sum = (DATA_W+1)'(ratio_y) + HALF_Q16;

        dx    = (DATA_W+1)'(nx_reg) - (DATA_W+1)'(last_x_reg);
        dy    = (DATA_W+1)'(ny_reg) - (DATA_W+1)'(last_y_reg);
        dd    = (DATA_W+1)'(nd_reg) - (DATA_W+1)'(last_d_reg);
        adx   = dx[DATA_W] ? -dx : dx;
        ady   = dy[DATA_W] ? -dy : dy;
        add_d = dd[DATA_W] ? -dd : dd;

        same = ($unsigned(adx) < (DATA_W+1)'(thr_reg)) &&
               ($unsigned(ady) < (DATA_W+1)'(thr_reg)) &&
               ((!nv_reg && !last_dv_reg) ||
                (nv_reg && last_dv_reg && ($unsigned(add_d) < (DATA_W+1)'(thr_reg))));
        moved = ok_reg && !same;
    end

    assign fin_fire = (state_reg == ST_FIN) && (!out_valid_reg || out_ch.ready);

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && (in_ch.kind == KIND_FRAME))
                    state_next = vp_ok ? ST_MAC : ST_FIN;
            end
            ST_MAC:
            begin
                if (mac_done)
                    state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                state_next = w_pos ? ST_DIV : ST_FIN;
            end
            ST_DIV:
            begin
                if (div_x_done)
                    state_next = ST_SCALE;
            end
            ST_SCALE: state_next = ST_SAT;
            ST_SAT:   state_next = ST_FIN;
            ST_FIN:
            begin
                if (fin_fire)
                    state_next = ST_IDLE;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            last_x_reg    <= '0;
            last_y_reg    <= '0;
            last_d_reg    <= '0;
            last_dv_reg   <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            if (fin_fire)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
            if (fin_fire && moved)
            begin
                last_x_reg  <= nx_reg;
                last_y_reg  <= ny_reg;
                last_d_reg  <= nd_reg;
                last_dv_reg <= nv_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            px_reg  <= in_ch.point_x;
            py_reg  <= in_ch.point_y;
            pz_reg  <= in_ch.point_z;
            ok_reg  <= 1'b0;
            vis_reg <= 1'b0;
        end
        if (state_reg == ST_CHECK)
        begin
            ok_reg  <= w_pos;
            vis_reg <= w_pos && in_box;
        end
        if (state_reg == ST_SCALE)
        begin
            prod_x_reg <= sx_sum * $signed({1'b0, vp_width_reg});
            prod_y_reg <= sy_sum * $signed({1'b0, vp_height_reg});
        end
        if (state_reg == ST_SAT)
        begin
            nx_reg <= sat32(prod_x_reg);
            ny_reg <= sat32(prod_y_reg);
            nd_reg <= ortho_reg ? '0 : sat32(clip.w);
            nv_reg <= !ortho_reg;
        end
        if (fin_fire)
        begin
            out_vis_reg   <= vis_reg;
            out_moved_reg <= moved;
            out_x_reg     <= moved ? nx_reg : last_x_reg;
            out_y_reg     <= moved ? ny_reg : last_y_reg;
            out_d_reg     <= moved ? nd_reg : last_d_reg;
            out_dv_reg    <= moved ? nv_reg : last_dv_reg;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.visible     = out_vis_reg;
    assign out_ch.moved       = out_moved_reg;
    assign out_ch.screen_x    = out_x_reg;
    assign out_ch.screen_y    = out_y_reg;
    assign out_ch.depth       = out_d_reg;
    assign out_ch.depth_valid = out_dv_reg;

`ifndef NO_ASSERTIONS
    a_mac_done_in_mac: assert property (@(posedge clk) disable iff (!rst_n)
        mac_done |-> (state_reg == ST_MAC))
        else $error("matrix pass finished outside its state");

    a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        div_x_done == div_y_done)
        else $error("x and y dividers out of step");

    a_div_to_scale: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) && div_x_done |=> (state_reg == ST_SCALE))
        else $error("divider result not taken");

    a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_FIN))
        else $error("result appeared outside the final step");
`endif

endmodule
`default_nettype wire

// File: hw/rtl/psp_mac.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psp_mac: matrix store and multiply-accumulate
// Holds the 4x4 matrix in a synchronous RAM and streams its 16 entries
// through one multiplier to form the four clip coordinates.
// ----------------------------------------------------------------------------
module psp_mac (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire psp_pkg::mat_wr_t wr,
    input  wire logic            start,
    input  wire psp_pkg::q16_t   px,
    input  wire psp_pkg::q16_t   py,
    input  wire psp_pkg::q16_t   pz,
    output logic                 done,
    output psp_pkg::clip_t       clip
);
    import psp_pkg::*;

    localparam logic [1:0] COL_X = 2'd0;
    localparam logic [1:0] COL_Y = 2'd1;
    localparam logic [1:0] COL_Z = 2'd2;
    localparam logic [1:0] COL_W = 2'd3;
    localparam logic [MAT_AW-1:0] LAST_ENTRY = MAT_AW'(MAT_DEPTH - 1);

    q16_t mem [MAT_DEPTH];
    q16_t rd_data_reg;

    logic              issue_reg, issue_next;
    logic [MAT_AW-1:0] raddr_reg, raddr_next;
    logic              s1_valid_reg;
    logic [MAT_AW-1:0] s1_idx_reg;
    logic              s2_valid_reg;
    logic [MAT_AW-1:0] s2_idx_reg;
    wide_t             term_reg;
    wide_t             acc_reg;
    wide_t             clip_reg [4];
    logic              done_reg;

    q16_t                        coord;
    logic signed [2*DATA_W-1:0]  prod;
    wide_t                       term;
    wide_t                       sum;

    // RAM: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr.we)
            mem[wr.addr] <= wr.data;
        rd_data_reg <= mem[raddr_reg];
    end

    always_comb
    begin
        issue_next = issue_reg;
        raddr_next = raddr_reg;
        if (start)
        begin
            issue_next = 1'b1;
            raddr_next = '0;
        end
        else if (issue_reg)
        begin
            raddr_next = raddr_reg + 1'b1;
            if (raddr_reg == LAST_ENTRY)
                issue_next = 1'b0;
        end
    end

    always_comb
    begin
        case (s1_idx_reg[1:0])
            COL_X:   coord = px;
            COL_Y:   coord = py;
            COL_Z:   coord = pz;
            default: coord = '0;
        endcase
        prod = rd_data_reg * coord;
        // w = 1: last column enters unscaled; others are floored to Q16.16
        if (s1_idx_reg[1:0] == COL_W)
            term = WIDE_W'(rd_data_reg);
        else
            term = WIDE_W'(prod >>> FRAC_W);
        sum = ((s2_idx_reg[1:0] == COL_X) ? '0 : acc_reg) + term_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_reg    <= 1'b0;
            raddr_reg    <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            issue_reg    <= issue_next;
            raddr_reg    <= raddr_next;
            s1_valid_reg <= issue_reg;
            s2_valid_reg <= s1_valid_reg;
            done_reg     <= s2_valid_reg && (s2_idx_reg == LAST_ENTRY);
        end
    end

    always_ff @(posedge clk)
    begin
        s1_idx_reg <= raddr_reg;
        s2_idx_reg <= s1_idx_reg;
        term_reg   <= term;
        if (s2_valid_reg)
        begin
            acc_reg <= sum;
            if (s2_idx_reg[1:0] == COL_W)
                clip_reg[s2_idx_reg[MAT_AW-1:2]] <= sum;
        end
    end

    assign done    = done_reg;
    assign clip.cx = clip_reg[0];
    assign clip.cy = clip_reg[1];
    assign clip.cz = clip_reg[2];
    assign clip.w  = clip_reg[3];

endmodule
`default_nettype wire

// File: hw/rtl/psp_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psp_div: saturating ratio divider
// Computes c / (2w) in Q16.16 as |c| * 2^15 / w, truncated, signed and
// saturated, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module psp_div (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire psp_pkg::wide_t num,
    input  wire psp_pkg::wide_t den,
    output logic               done,
    output psp_pkg::q16_t      quo
);
    import psp_pkg::*;

    localparam int MAG_W = WIDE_W - 1;
    localparam int HI_W  = MAG_W - FRAC_W;
    localparam int CNT_W = $clog2(QUO_BITS + 1);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(QUO_BITS - 1);

    logic [WIDE_W-1:0]   rem_reg;
    logic [QUO_BITS-1:0] low_reg;
    logic [QUO_BITS-1:0] q_reg;
    logic [WIDE_W-1:0]   den_reg;
    logic                neg_reg;
    logic                ovf_reg;
    logic                busy_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic                done_reg;

    wide_t             mag_full;
    logic [MAG_W-1:0]  mag;
    logic [HI_W-1:0]   hi;
    logic [WIDE_W-1:0] shifted;
    logic [WIDE_W:0]   diff;
    logic              ge;
    logic [DATA_W-1:0] q_ext;

    always_comb
    begin
        mag_full = num[WIDE_W-1] ? -num : num;
        mag      = mag_full[MAG_W-1:0];
        hi       = mag[MAG_W-1:FRAC_W];
        shifted  = {rem_reg[WIDE_W-2:0], low_reg[QUO_BITS-1]};
        diff     = {1'b0, shifted} - {1'b0, den_reg};
        ge       = !diff[WIDE_W];
        q_ext    = {1'b0, q_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            // |c|*2^15 split: upper part seeds the remainder, the rest shifts in
            rem_reg <= WIDE_W'(hi);
            low_reg <= {mag[FRAC_W-1:0], (QUO_BITS - FRAC_W)'(0)};
            den_reg <= $unsigned(den);
            neg_reg <= num[WIDE_W-1];
            // quotient reaches 2^31 exactly when the upper part is >= w
            ovf_reg <= (WIDE_W'(hi) >= $unsigned(den));
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[WIDE_W-1:0] : shifted;
            low_reg <= {low_reg[QUO_BITS-2:0], 1'b0};
            q_reg   <= {q_reg[QUO_BITS-2:0], ge};
        end
    end

    always_comb
    begin
        if (ovf_reg)
            quo = neg_reg ? Q16_MIN : Q16_MAX;
        else if (neg_reg)
            quo = -$signed(q_ext);
        else
            quo = $signed(q_ext);
    end

    assign done = done_reg;

endmodule
`default_nettype wire

// File: dv/point_screen_projector_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// point_screen_projector_checker: result predictor and comparator
// Follows the register port and both item channels, projects each accepted
// frame item and checks every result item against the oldest prediction.
// ----------------------------------------------------------------------------
module point_screen_projector_checker (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic                      pready,
    input  wire logic [psp_pkg::CFG_AW-1:0] paddr,
    input  wire logic [31:0]               pwdata,
    psp_in_if                              in_ch,
    psp_out_if                             out_ch,
    output int                             error_count,
    output int                             outstanding
);
    import psp_pkg::*;

    typedef struct packed {
        logic visible;
        logic moved;
        q16_t screen_x;
        q16_t screen_y;
        q16_t depth;
        logic depth_valid;
    } screen_fix_t;

    q16_t        vp_matrix [MAT_DEPTH];
    q16_t        held_x;
    q16_t        held_y;
    q16_t        held_depth;
    logic        held_dv;
    logic [15:0] vp_width;
    logic [15:0] vp_height;
    logic        ortho;
    logic [15:0] move_thr;
    screen_fix_t fix_q [$];

    function automatic longint mag64(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic longint clamp_q16(input longint v);
        if (v > longint'(Q16_MAX))
            return longint'(Q16_MAX);
        if (v < longint'(Q16_MIN))
            return longint'(Q16_MIN);
        return v;
    endfunction

    // one clip coordinate; products floored to Q16.16, summed at full width
    function automatic longint clip_row(input int row, input longint px,
                                        input longint py, input longint pz);
        longint acc;
        acc = (longint'(vp_matrix[row*4])     * px) >>> FRAC_W;
        acc += (longint'(vp_matrix[row*4 + 1]) * py) >>> FRAC_W;
        acc += (longint'(vp_matrix[row*4 + 2]) * pz) >>> FRAC_W;
        acc += longint'(vp_matrix[row*4 + 3]);
        return acc;
    endfunction

    // c / (2w): truncated toward zero, signed, saturated
    function automatic longint half_ratio(input longint c, input longint w);
        longint unsigned mag;
        longint unsigned quo;
        mag = mag64(c);
        mag = mag << 15;
        quo = mag / w;
        if (c >= 0)
            return (quo > 64'h7FFF_FFFF) ? longint'(Q16_MAX) : longint'(quo);
        return (quo >= 64'h8000_0000) ? longint'(Q16_MIN) : -longint'(quo);
    endfunction

    function automatic screen_fix_t project_point(input q16_t x, input q16_t y,
                                                  input q16_t z);
        screen_fix_t f;
        longint      cx;
        longint      cy;
        longint      cz;
        longint      w;
        longint      nx;
        longint      ny;
        longint      nd;
        longint      thr;
        logic        nv;
        logic        same;
        f = '0;
        if (vp_width != 0 && vp_height != 0)
        begin
            cx = clip_row(0, x, y, z);
            cy = clip_row(1, x, y, z);
            cz = clip_row(2, x, y, z);
            w  = clip_row(3, x, y, z);
            if (w > 0)
            begin
                thr = longint'(move_thr);
                nv = !ortho;
                f.visible = (mag64(cx) <= w) && (mag64(cy) <= w) && (mag64(cz) <= w);
                nx = clamp_q16((half_ratio(cx, w) + longint'(HALF_Q16)) *
                               longint'(vp_width));
                ny = clamp_q16((half_ratio(-cy, w) + longint'(HALF_Q16)) *
                               longint'(vp_height));
                nd = nv ? clamp_q16(w) : 0;
                same = (mag64(nx - held_x) < thr) && (mag64(ny - held_y) < thr) &&
                       ((!nv && !held_dv) ||
                        (nv && held_dv && (mag64(nd - held_depth) < thr)));
                if (!same)
                begin
                    held_x     = q16_t'(nx);
                    held_y     = q16_t'(ny);
                    held_depth = q16_t'(nd);
                    held_dv    = nv;
                    f.moved    = 1'b1;
                end
            end
        end
        f.screen_x    = held_x;
        f.screen_y    = held_y;
        f.depth       = held_depth;
        f.depth_valid = held_dv;
        return f;
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] got_v);
        if (got_v !== exp_v)
        begin
            $error("%s: expected %0d, got %0d", name, $signed(exp_v), $signed(got_v));
            error_count++;
        end
    endtask

    task automatic check_fix(input screen_fix_t exp_f);
        check_field("visible",     32'(exp_f.visible),     32'(out_ch.visible));
        check_field("moved",       32'(exp_f.moved),       32'(out_ch.moved));
        check_field("screen_x",    exp_f.screen_x,         out_ch.screen_x);
        check_field("screen_y",    exp_f.screen_y,         out_ch.screen_y);
        check_field("depth",       exp_f.depth,            out_ch.depth);
        check_field("depth_valid", 32'(exp_f.depth_valid), 32'(out_ch.depth_valid));
    endtask

    initial error_count = 0;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            foreach (vp_matrix[i])
                vp_matrix[i] = '0;
            held_x      = '0;
            held_y      = '0;
            held_depth  = '0;
            held_dv     = 1'b1;
            vp_width    = '0;
            vp_height   = '0;
            ortho       = 1'b0;
            move_thr    = THRESHOLD_RESET;
            fix_q.delete();
            outstanding <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (cfg_reg_t'(paddr[CFG_AW-1:2]))
                    REG_WIDTH:     vp_width  = pwdata[15:0];
                    REG_HEIGHT:    vp_height = pwdata[15:0];
                    REG_ORTHO:     ortho     = pwdata[0];
                    REG_THRESHOLD: move_thr  = pwdata[15:0];
                    default: ;
                endcase
            end
            // input first: a result never leaves in its own accept cycle
            if (in_ch.valid && in_ch.ready)
            begin
                if (in_ch.kind == KIND_LOAD)
                    vp_matrix[in_ch.entry_index] = in_ch.entry_value;
                else
                    fix_q.push_back(project_point(in_ch.point_x, in_ch.point_y,
                                                  in_ch.point_z));
            end
            if (out_ch.valid && out_ch.ready)
            begin
                if (fix_q.size() == 0)
                begin
                    $error("result item with no frame item outstanding");
                    error_count++;
                end
                else
                    check_fix(fix_q.pop_front());
            end
            outstanding <= fix_q.size();
        end
    end

endmodule
`default_nettype wire

// File: dv/point_screen_projector_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// point_screen_projector_tb: testbench top of the point screen projector
// Loads view-projection matrices, projects directed and random points under
// several viewport settings, and lets the checker compare every result item.
// ----------------------------------------------------------------------------
module point_screen_projector_tb;
    import psp_pkg::*;

    localparam int LATENCY_PAD   = 80;         // > one frame item, accept to result
    localparam int HOLD_CYCLES   = 400;        // long receiver hold-off
    localparam int PHASES        = 12;
    localparam int ITEMS_PER_RUN = 80;         // after the matrix reload of a phase
    localparam int IDLE_PCT      = 34;
    localparam int RUN_LIMIT     = 2_000_000;  // time units, several times a slow run

    logic              clk = 1'b0;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [CFG_AW-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    int error_count;
    int outstanding;

    // shared knobs between the stimulus and the result sink
    bit src_idle_on  = 1'b1;
    bit sink_idle_on = 1'b1;
    bit hold_req     = 1'b0;

    // last frame point sent, reused for small-move sequences
    q16_t last_px;
    q16_t last_py;
    q16_t last_pz;

    psp_in_if  in_ch ();
    psp_out_if out_ch ();

    point_screen_projector dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (in_ch),
        .out_ch  (out_ch)
    );

    point_screen_projector_checker fix_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .in_ch       (in_ch),
        .out_ch      (out_ch),
        .error_count (error_count),
        .outstanding (outstanding)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // hard stop in case the block hangs
    initial
    begin
        #RUN_LIMIT;
        $display("Test completed with failures");
        $finish;
    end

    // Result sink: random stalls, plus one long hold-off on request so the
    // block fills its output register and pipeline and backs up the input.
    initial
    begin : result_sink
        out_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            out_ch.ready <= !sink_idle_on || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // signed value spread evenly over [-span, span]
    function automatic q16_t spread(input int unsigned span);
        return q16_t'($urandom_range(2 * span)) - q16_t'(span);
    endfunction

    // viewport size: mostly random, often the extremes, sometimes not ready
    function automatic logic [15:0] pick_size();
        int unsigned r;
        r = $urandom_range(9);
        case (r)
            0:       return 16'd0;
            1:       return 16'd1;
            2:       return 16'hFFFF;
            default: return 16'($urandom_range(65535, 1));
        endcase
    endfunction

    function automatic logic [15:0] pick_threshold();
        int unsigned r;
        r = $urandom_range(4);
        case (r)
            0:       return 16'd0;
            1:       return THRESHOLD_RESET;
            2:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // All tasks below start and end just after a rising edge.

    // Setup cycle and access cycle, then psel is dropped.
    task automatic reg_write(input cfg_reg_t r, input logic [31:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_view(input logic [15:0] w, input logic [15:0] h,
                            input logic o, input logic [15:0] thr);
        reg_write(REG_WIDTH, 32'(w));
        reg_write(REG_HEIGHT, 32'(h));
        reg_write(REG_ORTHO, 32'(o));
        reg_write(REG_THRESHOLD, 32'(thr));
    endtask

    // Offer one item, with random idle cycles ahead of it, and return at the
    // edge that accepts it. valid stays high for a following item.
    task automatic offer(input kind_t k, input logic [3:0] idx, input q16_t val,
                         input q16_t x, input q16_t y, input q16_t z);
        while (src_idle_on && ($urandom_range(99) < IDLE_PCT))
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.kind        <= k;
        in_ch.entry_index <= idx;
        in_ch.entry_value <= val;
        in_ch.point_x     <= x;
        in_ch.point_y     <= y;
        in_ch.point_z     <= z;
        do
            @(posedge clk);
        while (!in_ch.ready);
    endtask

    // unused fields carry random bits
    task automatic load_entry(input logic [3:0] idx, input q16_t val);
        offer(KIND_LOAD, idx, val, q16_t'($urandom), q16_t'($urandom), q16_t'($urandom));
    endtask

    task automatic frame(input q16_t x, input q16_t y, input q16_t z);
        last_px = x;
        last_py = y;
        last_pz = z;
        offer(KIND_FRAME, 4'($urandom), q16_t'($urandom), x, y, z);
    endtask

    // Sender pause: wait for every outstanding result, then for the block's
    // latency, so the block is idle for register writes.
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (LATENCY_PAD) @(posedge clk);
    endtask

    // Perspective-like matrix: near-unit diagonal, small shear, w close to -z.
    // Noise matrices use full-range entries and mostly saturate or clip.
    task automatic load_matrix(input bit sane);
        int   row;
        int   col;
        q16_t v;
        for (int i = 0; i < MAT_DEPTH; i++)
        begin
            row = i / 4;
            col = i % 4;
            if (!sane)
                v = q16_t'($urandom);
            else if (row < 3 && col == row)
            begin
                v = q16_t'($urandom_range(32'h2_0000, 32'h8000));
                if ($urandom_range(1))
                    v = -v;
            end
            else if (row < 3)
                v = (col == 3) ? spread(32'h1_0000) : spread(32'h4000);
            else if (col == 2)
                v = -q16_t'(32'h1_0000) + spread(32'h2000);
            else if (col == 3)
                v = q16_t'($urandom_range(32'h8000));
            else
                v = spread(32'h1000);
            load_entry(4'(i), v);
        end
    endtask

    // Random items: mostly sane points in front of the camera, a share of
    // near repeats to exercise the move threshold, some noise, and the odd
    // matrix entry rewrite.
    task automatic random_items(input int n);
        int unsigned r;
        q16_t        x;
        q16_t        y;
        q16_t        z;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(99);
            if (r < 8)
                load_entry(4'($urandom_range(15)),
                           $urandom_range(1) ? spread(32'h2_0000) : q16_t'($urandom));
            else
            begin
                r = $urandom_range(99);
                if (r < 55)
                begin
                    x = spread(32'h3_0000);
                    y = spread(32'h3_0000);
                    z = -q16_t'($urandom_range(32'h8_0000, 32'h8000));
                    if ($urandom_range(9) == 0)
                        z = -z;  // behind the camera
                end
                else if (r < 80)
                begin
                    x = last_px;
                    y = last_py;
                    z = last_pz;
                    if ($urandom_range(1))
                    begin
                        x += spread(3);
                        y += spread(3);
                        z += spread(3);
                    end
                end
                else
                begin
                    x = q16_t'($urandom);
                    y = q16_t'($urandom);
                    z = q16_t'($urandom);
                end
                frame(x, y, z);
            end
        end
    endtask

    initial
    begin
        rst_n             <= 1'b0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        in_ch.valid       <= 1'b0;
        in_ch.kind        <= KIND_LOAD;
        in_ch.entry_index <= '0;
        in_ch.entry_value <= '0;
        in_ch.point_x     <= '0;
        in_ch.point_y     <= '0;
        in_ch.point_z     <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // --- directed part ---
        // identity view with w = -z; entries that stay zero are written too
        for (int i = 0; i < MAT_DEPTH; i++)
            load_entry(4'(i), (i == 0 || i == 5 || i == 10) ? q16_t'(32'h1_0000) :
                              (i == 14) ? -q16_t'(32'h1_0000) : q16_t'(0));

        // viewport still zero after reset: invisible, reset position held
        frame(0, 0, -q16_t'(32'h2_0000));
        drain();
        set_view(16'd640, 16'd480, 1'b0, THRESHOLD_RESET);

        frame(0, 0, -q16_t'(32'h2_0000));                   // center, visible
        frame(0, 0, -q16_t'(32'h2_0000));                   // same point, no move
        frame(1, -1, -q16_t'(32'h2_0000));                  // sub-threshold change
        frame(0, 0, q16_t'(32'h1_0000));                    // behind camera
        frame(0, 0, 0);                                     // w exactly zero
        frame(q16_t'(32'h5_0000), 0, -q16_t'(32'h2_0000));  // off screen, in front
        frame(q16_t'(32'h2_0000), -q16_t'(32'h2_0000),
              -q16_t'(32'h2_0000));                         // on the clip boundary
        frame(Q16_MAX, Q16_MIN, -1);                        // ratio and screen saturate
        frame(Q16_MIN, Q16_MAX, Q16_MIN);                   // depth saturates
        drain();

        // orthographic: depth turns invalid, then two invalid depths match
        set_view(16'd640, 16'd480, 1'b1, THRESHOLD_RESET);
        frame(0, 0, -q16_t'(32'h2_0000));
        frame(0, 0, -q16_t'(32'h2_0000));

        // --- random part, one setting per phase ---
        for (int p = 0; p < PHASES; p++)
        begin
            drain();
            case (p)
                0:       set_view(16'hFFFF, 16'd1, 1'b0, 16'd0);
                1:       set_view(16'd1, 16'hFFFF, 1'b1, 16'hFFFF);
                default: set_view(pick_size(), pick_size(), 1'($urandom_range(1)),
                                  pick_threshold());
            endcase
            // one phase runs at full rate on both sides
            src_idle_on  = (p != 3);
            sink_idle_on = (p != 3);
            if (p == 2)
                hold_req = 1'b1;
            load_matrix($urandom_range(3) != 0);
            random_items(ITEMS_PER_RUN);
        end
        drain();

        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
`default_nettype wire

// File: sim.f
hw/rtl/psp_pkg.sv
hw/rtl/psp_in_if.sv
hw/rtl/psp_out_if.sv
hw/rtl/psp_mac.sv
hw/rtl/psp_div.sv
hw/rtl/point_screen_projector.sv
dv/point_screen_projector_checker.sv
dv/point_screen_projector_tb.sv
